// ===== rtl/ame_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine execute: shared package
// Types, opcodes and constants used by the front, queue and back.
// ----------------------------------------------------------------------------
package ame_pkg;

  // The word count is a power of two, so an address is the low index bits.
  localparam int MEM_WORDS = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] SIGN_BIT24 = 32'h0080_0000;
  localparam logic [31:0] HIGH_FILL  = 32'hff00_0000;
  localparam logic [31:0] LOW24_MASK = 32'h00ff_ffff;

  localparam logic [4:0] OPC_LIT       = 5'd0;
  localparam logic [4:0] OPC_LITX      = 5'd1;
  localparam logic [4:0] OPC_LITM      = 5'd2;
  localparam logic [4:0] OPC_LOAD      = 5'd3;
  localparam logic [4:0] OPC_LOAD_IND  = 5'd4;
  localparam logic [4:0] OPC_STORE     = 5'd5;
  localparam logic [4:0] OPC_STORE_IND = 5'd6;
  localparam logic [4:0] OPC_ADD_IMM   = 5'd7;
  localparam logic [4:0] OPC_ADD_IND   = 5'd11;
  localparam logic [4:0] OPC_SUB_IMM   = 5'd12;
  localparam logic [4:0] OPC_SUB_IND   = 5'd16;

  typedef enum logic [2:0] {
    K_SET,
    K_STORE,
    K_ADD,
    K_SUB,
    K_NONE
  } kind_t;

  typedef enum logic [2:0] {
    F_IMM,
    F_SX,
    F_MERGE,
    F_DIR,
    F_IND
  } form_t;

  typedef struct packed {
    kind_t       kind;
    form_t       form;
    logic [23:0] x;
  } dec_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RD1,
    S_RD2
  } back_state_t;

endpackage

// ===== rtl/ame_instr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine execute: instruction channel
// Valid/ready channel that carries one instruction per beat.
// ----------------------------------------------------------------------------
interface ame_instr_if;
  logic        valid;
  logic        ready;
  logic [4:0]  mode;
  logic [23:0] operand;

  modport source (output valid, output mode, output operand, input ready);
  modport sink (input valid, input mode, input operand, output ready);
endinterface

// ===== rtl/ame_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine execute: result channel
// Valid/ready channel that carries the accumulator after each instruction.
// ----------------------------------------------------------------------------
interface ame_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] acc_value;
  logic               acc_positive;

  modport source (output valid, output acc_value, output acc_positive, input ready);
  modport sink (input valid, input acc_value, input acc_positive, output ready);
endinterface

// ===== rtl/ame_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine execute: front
// Accepts instruction beats and decodes them into an operation and form.
// ----------------------------------------------------------------------------
module ame_front import ame_pkg::*; (
  ame_instr_if.sink instr,
  input  logic      clearing,
  input  logic      full,
  output logic      push,
  output dec_t      dec
);

  assign instr.ready = !full && !clearing;
  assign push        = instr.valid && instr.ready;

  always_comb begin
    dec.x    = instr.operand;
    dec.kind = K_NONE;
    dec.form = F_IMM;
    unique case (instr.mode) inside
      OPC_LIT: begin
        dec.kind = K_SET;
        dec.form = F_IMM;
      end
      OPC_LITX: begin
        dec.kind = K_SET;
        dec.form = F_SX;
      end
      OPC_LITM: begin
        dec.kind = K_SET;
        dec.form = F_MERGE;
      end
      OPC_LOAD: begin
        dec.kind = K_SET;
        dec.form = F_DIR;
      end
      OPC_LOAD_IND: begin
        dec.kind = K_SET;
        dec.form = F_IND;
      end
      OPC_STORE: begin
        dec.kind = K_STORE;
        dec.form = F_DIR;
      end
      OPC_STORE_IND: begin
        dec.kind = K_STORE;
        dec.form = F_IND;
      end
      [OPC_ADD_IMM:OPC_ADD_IND]: begin
        dec.kind = K_ADD;
        dec.form = form_t'(3'(instr.mode - OPC_ADD_IMM));
      end
      [OPC_SUB_IMM:OPC_SUB_IND]: begin
        dec.kind = K_SUB;
        dec.form = form_t'(3'(instr.mode - OPC_SUB_IMM));
      end
      default: begin
        dec.kind = K_NONE;
        dec.form = F_IMM;
      end
    endcase
  end

endmodule

// ===== rtl/ame_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine execute: decoded instruction queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module ame_queue import ame_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  dec_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output dec_t head
);

  dec_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ame_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine execute: back
// Sequences memory reads and writes, updates the registers, holds the result.
// ----------------------------------------------------------------------------
module ame_back import ame_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  dec_t          head,
  output logic          pop,
  output logic          clearing,
  ame_result_if.source  result
);

  back_state_t state, state_next;

  logic [31:0]       mem [MEM_WORDS];
  logic [31:0]       rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [31:0]       mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;

  logic [ADDR_W-1:0] clr_idx;
  logic [31:0]       accumulator, accumulator_next;
  logic [31:0]       operand_reg, operand_reg_next;
  logic [31:0]       value;
  logic [31:0]       target;
  dec_t              cur;
  dec_t              op;
  logic              cur_load;
  logic              fire;
  logic              out_free;
  logic              rvalid;
  logic [31:0]       acc_out;
  logic              pos_out;

  assign clearing            = state == S_CLEAR;
  assign out_free            = !rvalid || result.ready;
  assign result.valid        = rvalid;
  assign result.acc_value    = acc_out;
  assign result.acc_positive = pos_out;

  assign op = (state == S_IDLE) ? head : cur;

  always_comb begin
    target = (op.kind == K_SET) ? accumulator : operand_reg;
    case (op.form)
      F_IMM:   value = {8'h00, op.x};
      F_SX:    value = (({8'h00, op.x} & SIGN_BIT24) != '0) ? (HIGH_FILL | {8'h00, op.x})
                                                             : {8'h00, op.x};
      F_MERGE: value = {op.x, 8'h00} | (target & LOW24_MASK);
      default: value = rd_data;
    endcase
    accumulator_next = accumulator;
    operand_reg_next = operand_reg;
    case (op.kind)
      K_SET: accumulator_next = value;
      K_ADD: begin
        operand_reg_next = value;
        accumulator_next = accumulator + value;
      end
      K_SUB: begin
        operand_reg_next = value;
        accumulator_next = accumulator - value;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wa     = op.x[ADDR_W-1:0];
    mem_wd     = accumulator;
    mem_re     = 1'b0;
    mem_ra     = op.x[ADDR_W-1:0];
    pop        = 1'b0;
    fire       = 1'b0;
    cur_load   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
        mem_wd = '0;
        if (clr_idx == ADDR_W'(MEM_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid) begin
          if (head.form == F_DIR || head.form == F_IND) begin
            if (head.kind == K_STORE && head.form == F_DIR) begin
              if (out_free) begin
                mem_we = 1'b1;
                fire   = 1'b1;
                pop    = 1'b1;
              end
            end else begin
              mem_re     = 1'b1;
              pop        = 1'b1;
              cur_load   = 1'b1;
              state_next = S_RD1;
            end
          end else if (out_free) begin
            fire = 1'b1;
            pop  = 1'b1;
          end
        end
      end
      S_RD1: begin
        if (cur.form == F_IND) begin
          if (cur.kind == K_STORE) begin
            if (out_free) begin
              mem_we     = 1'b1;
              mem_wa     = rd_data[ADDR_W-1:0];
              fire       = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            mem_re     = 1'b1;
            mem_ra     = rd_data[ADDR_W-1:0];
            state_next = S_RD2;
          end
        end else if (out_free) begin
          fire       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD2: begin
        if (out_free) begin
          fire       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur <= head;
    end
    if (fire) begin
      acc_out <= accumulator_next;
      pos_out <= (accumulator_next != '0) && !accumulator_next[31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      accumulator <= '0;
      operand_reg <= '0;
      rvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (fire) begin
        accumulator <= accumulator_next;
        operand_reg <= operand_reg_next;
        rvalid      <= 1'b1;
      end else if (result.ready) begin
        rvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/accumulator_machine_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator machine execute: top level
// Decoding front, instruction queue and executing back with its data memory.
// ----------------------------------------------------------------------------
// After reset the block clears its 4096-word data memory, one word a cycle,
// and takes no instruction until the clear is done. From then on it executes one
// instruction per beat and returns one result beat per instruction, in order.
// The back uses one memory port with a registered read, which sets the path of
// each form: literal, merge, immediate arithmetic, direct store and unknown
// opcodes finish from idle, direct load, indirect store and direct arithmetic
// pass through the first read state, and indirect load and indirect arithmetic
// through both read states. A two-entry queue lets new beats be taken while
// the back works and a result waits to be taken.
// ----------------------------------------------------------------------------
module accumulator_machine_execute import ame_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ame_instr_if.sink    instr,
  ame_result_if.source result
);

  logic clearing;
  logic full;
  logic push;
  dec_t dec;
  logic pop;
  logic head_valid;
  dec_t head;

  ame_front u_front (
    .instr    (instr),
    .clearing (clearing),
    .full     (full),
    .push     (push),
    .dec      (dec)
  );

  ame_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (dec),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ame_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .result     (result)
  );

endmodule
